// File: rtl/decimal_text_to_fixed_point_top_defines.svh
// Assertion macros for the checker file.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH

// Checked only outside reset.
`define DTF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("dtf assertion failed");

// Checked at every edge, reset included.
`define DTF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("dtf assertion failed");

`endif

// File: rtl/dtf_pkg.sv
package dtf_pkg;

    // Widths of the parsed record. These are the largest supported sizes.
    localparam int JOB_INT_W  = 31;
    localparam int FRAC_ACC_W = 30;
    localparam int CNT_W      = 4;

    // Queue depth between parser and converter
    localparam int Q_DEPTH = 2;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // One finished string, as handed from parser to converter
    typedef struct packed {
        logic                  neg;
        logic                  sat;
        logic [JOB_INT_W-1:0]  int_part;
        logic [FRAC_ACC_W-1:0] frac_acc;
        logic [CNT_W-1:0]      frac_cnt;
    } t_job;

    // Powers of ten for the fraction divisor
    function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [CNT_W-1:0] n);
        logic [FRAC_ACC_W-1:0] p;
        begin
            case (n)
                4'd0:    p = 30'd1;
                4'd1:    p = 30'd10;
                4'd2:    p = 30'd100;
                4'd3:    p = 30'd1000;
                4'd4:    p = 30'd10000;
                4'd5:    p = 30'd100000;
                4'd6:    p = 30'd1000000;
                4'd7:    p = 30'd10000000;
                4'd8:    p = 30'd100000000;
                default: p = 30'd1000000000;
            endcase
            return p;
        end
    endfunction

endpackage

// File: rtl/decimal_text_to_fixed_point_top.sv
// Input: one byte per cycle, accepted every cycle while the result queue has room.
// Result path: queue, idle load, the one-bit-per-cycle fraction divider, rounding, and the
// output register, which waits for a free slot; the converter handles one string at a time.
// A two-entry queue holds finished strings, so the parser keeps streaming meanwhile.
// Synchronous active-low reset returns parser, queue and converter to idle, empty.
module decimal_text_to_fixed_point_top #(
    parameter int FRAC_DIGITS = 9,
    parameter int FRAC_BITS   = 32,
    parameter int INT_BITS    = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_fixed_value,
    output logic        o_overflow
);
    import dtf_pkg::*;

    logic accept;
    logic job_push, job_pop, job_empty;
    t_job job_in, job_out;

    assign accept = push && !full;

    // Parser: classifies bytes and accumulates digits
    dtf_front #(
        .FRAC_DIGITS(FRAC_DIGITS),
        .INT_BITS   (INT_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_text_byte(i_text_byte),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    // Decoupling queue
    dtf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_job  (job_in),
        .o_full (full),
        .i_pop  (job_pop),
        .o_empty(job_empty),
        .o_job  (job_out)
    );

    // Converter: fraction divide, round, sign
    dtf_back #(
        .FRAC_BITS(FRAC_BITS),
        .INT_BITS (INT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (job_empty),
        .i_job        (job_out),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_fixed_value(o_fixed_value),
        .o_overflow   (o_overflow)
    );

endmodule

// File: rtl/dtf_front.sv
module dtf_front #(
    parameter int FRAC_DIGITS = 9,
    parameter int INT_BITS    = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_text_byte,
    output logic          o_job_push,
    output dtf_pkg::t_job o_job
);
    import dtf_pkg::*;

    localparam int IW = INT_BITS + 4;
    localparam logic [IW-1:0] INT_LIMIT = {4'b0, {INT_BITS{1'b1}}};

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    t_phase                r_phase, n_phase;
    logic                  r_neg, n_neg;
    logic                  r_sat, n_sat;
    logic [INT_BITS-1:0]   r_int, n_int;
    logic [FRAC_ACC_W-1:0] r_frac, n_frac;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic                  is_ws, is_sign, is_digit, is_dot, is_term;
    logic [3:0]            digit;
    logic [IW-1:0]         int_next;
    logic [FRAC_ACC_W-1:0] frac_next;
    logic                  int_over;

    // Byte classes
    assign is_ws    = (i_text_byte == CH_SPACE) ||
                      ((i_text_byte >= CH_TAB) && (i_text_byte <= CH_CR));
    assign is_sign  = (i_text_byte == CH_PLUS) || (i_text_byte == CH_MINUS);
    assign is_digit = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
    assign is_dot   = (i_text_byte == CH_DOT);
    assign is_term  = (i_text_byte == CH_NUL);
    assign digit    = i_text_byte[3:0];

    // acc * 10 + digit, as shifts and adds
    assign int_next  = (IW'(r_int) << 3) + (IW'(r_int) << 1) + IW'(digit);
    assign int_over  = int_next > INT_LIMIT;
    assign frac_next = (r_frac << 3) + (r_frac << 1) + FRAC_ACC_W'(digit);

    // Finished record goes to the queue on the terminator beat
    assign o_job_push     = i_accept && is_term;
    assign o_job.neg      = r_neg;
    assign o_job.sat      = r_sat;
    assign o_job.int_part = JOB_INT_W'(r_int);
    assign o_job.frac_acc = r_frac;
    assign o_job.frac_cnt = r_cnt;

    // Next-state parser logic
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_sat   = r_sat;
        n_int   = r_int;
        n_frac  = r_frac;
        n_cnt   = r_cnt;
        if (i_accept) begin
            if (is_term) begin
                n_phase = PH_SKIP;
                n_neg   = 1'b0;
                n_sat   = 1'b0;
                n_int   = '0;
                n_frac  = '0;
                n_cnt   = '0;
            end else begin
                unique case (r_phase)
                    PH_SKIP, PH_SIGNED: begin
                        if (r_phase == PH_SKIP && is_ws) begin
                            n_phase = PH_SKIP;
                        end else if (is_sign) begin
                            if (r_phase == PH_SKIP) begin
                                n_neg   = (i_text_byte == CH_MINUS);
                                n_phase = PH_SIGNED;
                            end else begin
                                // second sign: result is zero
                                n_neg   = 1'b0;
                                n_int   = '0;
                                n_phase = PH_DONE;
                            end
                        end else if (is_digit) begin
                            n_int   = int_over ? INT_LIMIT[INT_BITS-1:0]
                                               : int_next[INT_BITS-1:0];
                            n_sat   = r_sat | int_over;
                            n_phase = PH_INT;
                        end else if (is_dot) begin
                            n_phase = PH_FRAC;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_INT: begin
                        if (is_digit) begin
                            n_int = int_over ? INT_LIMIT[INT_BITS-1:0]
                                             : int_next[INT_BITS-1:0];
                            n_sat = r_sat | int_over;
                        end else if (is_dot) begin
                            n_phase = PH_FRAC;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit) begin
                            // digits past the limit are eaten silently
                            if (r_cnt < CNT_W'(FRAC_DIGITS)) begin
                                n_frac = frac_next;
                                n_cnt  = r_cnt + 1'b1;
                            end
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: n_phase = PH_DONE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_sat   <= 1'b0;
            r_int   <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_sat   <= n_sat;
            r_int   <= n_int;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: rtl/dtf_fifo.sv
module dtf_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dtf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output dtf_pkg::t_job o_job
);
    import dtf_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/dtf_back.sv
module dtf_back #(
    parameter int FRAC_BITS = 32,
    parameter int INT_BITS  = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_empty,
    input  dtf_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [63:0]   o_fixed_value,
    output logic          o_overflow
);
    import dtf_pkg::*;

    localparam int QW = FRAC_BITS + 1;             // quotient bits (2x scaled)
    localparam int RW = FRAC_ACC_W + 1;            // remainder bits
    localparam int SW = $clog2(QW + 1);            // step counter
    localparam int MW = INT_BITS + FRAC_BITS;      // magnitude bits
    localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_FIN,
        B_OUT
    } t_bstate;

    t_bstate               r_state;
    logic                  r_neg, r_ovf;
    logic [INT_BITS-1:0]   r_int;
    logic [FRAC_ACC_W-1:0] r_den;
    logic [RW-1:0]         r_rem;
    logic [QW-1:0]         r_quo;
    logic [SW-1:0]         r_step;
    logic [FRAC_BITS-1:0]  r_frac;
    logic                  r_valid;
    logic [63:0]           r_value;
    logic                  r_out_ovf;

    logic [RW-1:0]         rem_sh;
    logic                  q_bit;
    logic [QW:0]           quo_inc;
    logic [QW-1:0]         frac_rnd;
    logic [63:0]           mag;
    logic                  slot_free;

    assign o_job_pop     = (r_state == B_IDLE) && !i_job_empty;
    assign o_empty       = !r_valid;
    assign o_fixed_value = r_value;
    assign o_overflow    = r_out_ovf;
    assign slot_free     = !r_valid || i_pop;

    // One restoring divide step: remainder stays below the divisor
    assign rem_sh = {r_rem[RW-2:0], 1'b0};
    assign q_bit  = rem_sh >= RW'(r_den);

    // Round half up: floor((floor(2x/d) + 1) / 2)
    assign quo_inc  = (QW+1)'(r_quo) + 1'b1;
    assign frac_rnd = quo_inc[QW:1];

    // Sign applied by two's complement
    assign mag = 64'({r_int, r_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_valid   <= 1'b0;
            r_step    <= '0;
        end else begin
            // slot drains on a pop unless a new result loads in the same cycle
            if (i_pop && r_valid && !((r_state == B_OUT) && slot_free)) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_neg   <= i_job.neg;
                        r_ovf   <= i_job.sat;
                        r_int   <= i_job.int_part[INT_BITS-1:0];
                        r_den   <= pow10(i_job.frac_cnt);
                        r_rem   <= RW'(i_job.frac_acc);
                        r_quo   <= '0;
                        r_step  <= '0;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem  <= q_bit ? rem_sh - RW'(r_den) : rem_sh;
                    r_quo  <= {r_quo[QW-2:0], q_bit};
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(QW - 1)) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    // fraction rounded up to one: carry or saturate
                    if (frac_rnd[FRAC_BITS]) begin
                        if (r_int == INT_MAX) begin
                            r_frac <= {FRAC_BITS{1'b1}};
                            r_ovf  <= 1'b1;
                        end else begin
                            r_int  <= r_int + 1'b1;
                            r_frac <= '0;
                        end
                    end else begin
                        r_frac <= frac_rnd[FRAC_BITS-1:0];
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (slot_free) begin
                        r_value   <= r_neg ? (~mag + 64'd1) : mag;
                        r_out_ovf <= r_ovf;
                        r_valid   <= 1'b1;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/dtf_checker.sv
`include "decimal_text_to_fixed_point_top_defines.svh"

module dtf_checker #(
    parameter int FRAC_BITS = 32,
    parameter int INT_BITS  = 31
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [63:0] o_fixed_value,
    input logic        o_overflow
);
    localparam int TOP = INT_BITS + FRAC_BITS;

    // Reset leaves both sides empty
    `DTF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (empty && !full))

    // A waiting result holds until popped
    `DTF_ASSERT(a_result_holds, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_fixed_value) && $stable(o_overflow)))

    // Results never exceed the Q format: upper bits are sign copies
    `DTF_ASSERT(a_sign_extended, i_clk, i_rst_n, !empty |-> ((&o_fixed_value[63:TOP]) || !(|o_fixed_value[63:TOP])))

endmodule

bind decimal_text_to_fixed_point_top dtf_checker #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
) u_dtf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_fixed_value(o_fixed_value),
    .o_overflow   (o_overflow)
);

// File: sim/decimal_text_to_fixed_point_top_tb.sv
`timescale 1ns / 1ps

module decimal_text_to_fixed_point_top_tb;
    import dtf_pkg::*;

    localparam int N_FRAC_DIGITS = 9;
    localparam int N_FRAC_BITS   = 32;
    localparam int N_INT_BITS    = 31;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_NUMBER_BYTES = 1500;
    localparam int TOTAL_BYTES         = 1850;
    localparam int STEADY_BYTES        = 300;

    localparam longint unsigned FRAC_ONE = 64'd1 << N_FRAC_BITS;
    localparam longint unsigned INT_MAX  = (64'd1 << N_INT_BITS) - 64'd1;

    // Scanner phases of the predictor
    typedef enum logic [2:0] {
        SCAN_WS,
        SCAN_SIGN,
        SCAN_INT,
        SCAN_FRAC,
        SCAN_STOP
    } t_scan;

    typedef struct {
        logic [63:0] value;
        logic        ovf;
    } t_fixed_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_text_byte = 8'h00;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [63:0] o_fixed_value;
    logic        o_overflow;

    decimal_text_to_fixed_point_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .empty         (empty),
        .pop           (pop),
        .o_fixed_value (o_fixed_value),
        .o_overflow    (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    t_scan       scan_phase = SCAN_WS;
    logic        num_neg = 1'b0;
    logic [30:0] int_acc = '0;
    logic [29:0] frac_acc = '0;
    logic [3:0]  frac_cnt = '0;
    logic        int_sat = 1'b0;

    t_fixed_result expected_numbers[$];
    logic [7:0]    text_buf[$];

    bit steady = 1'b0;
    int bytes_sent = 0;
    int strings_sent = 0;
    int results_checked = 0;
    int saturated_seen = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    function automatic bit is_digit_ch(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sign_ch(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    // Integer digit with saturation at the top of the integer range
    function automatic void add_int_digit(input logic [7:0] c);
        longint unsigned v;
        v = 64'(int_acc) * 64'd10 + 64'(c - CH_ZERO);
        if (v > INT_MAX) begin
            v = INT_MAX;
            int_sat = 1'b1;
        end
        int_acc = v[30:0];
    endfunction

    // Terminator: round the fraction once, apply the sign, queue the number
    function automatic void close_number();
        longint unsigned den;
        longint unsigned frac;
        longint unsigned ip;
        longint unsigned mag;
        logic            ovf;
        int              k;
        ip   = 64'(int_acc);
        ovf  = int_sat;
        frac = 0;
        if (frac_cnt != 0) begin
            den = 1;
            for (k = 0; k < frac_cnt && k < N_FRAC_DIGITS; k++) den = den * 10;
            frac = 64'(frac_acc);
            frac = ((frac << N_FRAC_BITS) + den / 2) / den;
        end
        if (frac >= FRAC_ONE) begin
            if (ip >= INT_MAX) begin
                frac = FRAC_ONE - 1;
                ovf  = 1'b1;
            end else begin
                ip   = ip + 1;
                frac = frac - FRAC_ONE;
            end
        end
        mag = (ip << N_FRAC_BITS) + frac;
        if (num_neg) mag = ~mag + 1;
        expected_numbers.push_back('{value: mag, ovf: ovf});
        scan_phase = SCAN_WS;
        num_neg    = 1'b0;
        int_acc    = '0;
        frac_acc   = '0;
        frac_cnt   = '0;
        int_sat    = 1'b0;
    endfunction

    // Predictor: one accepted text byte
    function automatic void parse_char(input logic [7:0] c);
        if (c == CH_NUL) begin
            close_number();
            return;
        end
        case (scan_phase)
            SCAN_WS: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                end else if (is_sign_ch(c)) begin
                    num_neg    = (c == CH_MINUS);
                    scan_phase = SCAN_SIGN;
                end else if (is_digit_ch(c)) begin
                    add_int_digit(c);
                    scan_phase = SCAN_INT;
                end else if (c == CH_DOT) begin
                    scan_phase = SCAN_FRAC;
                end else begin
                    scan_phase = SCAN_STOP;
                end
            end
            SCAN_SIGN: begin
                if (is_sign_ch(c)) begin
                    // second sign kills the number
                    num_neg    = 1'b0;
                    int_acc    = '0;
                    scan_phase = SCAN_STOP;
                end else if (is_digit_ch(c)) begin
                    add_int_digit(c);
                    scan_phase = SCAN_INT;
                end else if (c == CH_DOT) begin
                    scan_phase = SCAN_FRAC;
                end else begin
                    scan_phase = SCAN_STOP;
                end
            end
            SCAN_INT: begin
                if (is_digit_ch(c)) add_int_digit(c);
                else if (c == CH_DOT) scan_phase = SCAN_FRAC;
                else scan_phase = SCAN_STOP;
            end
            SCAN_FRAC: begin
                if (is_digit_ch(c)) begin
                    // digits past the kept count are swallowed
                    if (frac_cnt < N_FRAC_DIGITS) begin
                        frac_acc = 30'(frac_acc * 10 + (c - CH_ZERO));
                        frac_cnt = frac_cnt + 4'd1;
                    end
                end else begin
                    scan_phase = SCAN_STOP;
                end
            end
            default: scan_phase = SCAN_STOP;
        endcase
    endfunction

    // One beat into the block, with random idling ahead of it outside the steady stretch
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < 15) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_text_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_char(b);
        bytes_sent++;
    endtask

    // Send the assembled text followed by its terminator
    task automatic send_buffer();
        foreach (text_buf[i]) send_byte(text_buf[i]);
        send_byte(CH_NUL);
        text_buf.delete();
        strings_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) text_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
    endtask

    // Empty text, negative zero, double sign, sign with a bare dot
    task automatic test_sign_cases();
        send_buffer();
        add_text("-0");
        send_buffer();
        add_text("+-");
        send_buffer();
        add_text("-.");
        send_buffer();
    endtask

    // Whitespace skip, fraction, stray byte and top byte value after the stop
    task automatic test_whitespace_and_stray();
        add_text(" \t+7.5x");
        text_buf.push_back(8'hFF);
        send_buffer();
    endtask

    task automatic test_integer_saturation();
        add_text("-9999999999");
        send_buffer();
    endtask

    // Mostly well-formed numbers with random content, first stretch without idling
    task automatic test_random_numbers(input int byte_goal);
        int sel;
        steady = 1'b1;
        while (bytes_sent < byte_goal) begin
            if (steady && bytes_sent > STEADY_BYTES) steady = 1'b0;
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(1)) text_buf.push_back(CH_SPACE);
                else text_buf.push_back(8'($urandom_range(CH_TAB, CH_CR)));
            end
            sel = $urandom_range(9);
            if (sel < 5) begin
                text_buf.push_back(sel < 3 ? CH_MINUS : CH_PLUS);
                if ($urandom_range(9) == 0)
                    text_buf.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            end
            sel = $urandom_range(9);
            case (sel)
                0: ;
                1: begin
                    // right around the saturation point
                    add_text("214748364");
                    add_digits(1);
                end
                2: add_digits($urandom_range(10, 12));
                default: add_digits($urandom_range(1, 5));
            endcase
            if ($urandom_range(3) != 0) begin
                text_buf.push_back(CH_DOT);
                add_digits($urandom_range(0, 12));
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
            send_buffer();
        end
        steady = 1'b0;
    endtask

    // Noise and broken sequences
    task automatic test_random_noise(input int byte_goal);
        string alphabet;
        alphabet = " +-.0123456789x\t";
        while (bytes_sent < byte_goal) begin
            repeat ($urandom_range(0, 8)) begin
                if ($urandom_range(1))
                    text_buf.push_back(8'($urandom_range(1, 255)));
                else
                    text_buf.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
            end
            send_buffer();
        end
    endtask

    // Result side: random back-pressure
    always @(posedge i_clk) begin
        pop <= steady || ($urandom_range(99) >= 15);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_fixed_result exp_num;
        if (i_rst_n && pop && !empty) begin
            if (expected_numbers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result value=%h ovf=%b",
                             o_fixed_value, o_overflow);
            end else begin
                exp_num = expected_numbers.pop_front();
                results_checked++;
                if (exp_num.ovf) saturated_seen++;
                if (o_fixed_value !== exp_num.value || o_overflow !== exp_num.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d value exp=%h act=%h ovf exp=%b act=%b",
                                 results_checked, exp_num.value, o_fixed_value,
                                 exp_num.ovf, o_overflow);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_sign_cases();
        test_whitespace_and_stray();
        test_integer_saturation();
        test_random_numbers(RANDOM_NUMBER_BYTES);
        test_random_noise(TOTAL_BYTES);
        push <= 1'b0;

        while (expected_numbers.size() != 0) @(posedge i_clk);
        repeat (N_FRAC_BITS + 8) @(posedge i_clk);
        mismatches += expected_numbers.size();

        $display("Parsed %0d strings over %0d text bytes; %0d numbers checked, %0d saturated.",
                 strings_sent, bytes_sent, results_checked, saturated_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
